@@ hw/rtl/mts_pkg.sv @@
package mts_pkg;

    // stack geometry
    localparam int STACK_DEPTH  = 1024;
    localparam int DATA_WIDTH   = 32;
    localparam int ENTRY_WIDTH  = DATA_WIDTH + 2;
    localparam int ADDR_WIDTH   = $clog2(STACK_DEPTH);
    localparam int COUNT_WIDTH  = $clog2(STACK_DEPTH + 1);
    localparam int OP_WIDTH     = 3;
    localparam int STATUS_WIDTH = 2;

    // request codes
    typedef enum logic [OP_WIDTH-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_EMPTY = 3'd3,
        OP_MIN   = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STATUS_WIDTH-1:0] {
        STAT_OK        = 2'd0,
        STAT_WAS_EMPTY = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    // sequencer states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

endpackage

@@ hw/rtl/min_tracking_stack_unit.sv @@
// channel   | valid       | ready        | payload
// request   | i_in_valid  | o_in_ready   | i_op, i_push_value
// result    | o_out_valid | i_out_ready  | o_result_value, o_stack_empty, o_status
//
// each request reads the top entry from the synchronous entry memory on acceptance,
// then in the execute state decodes it and updates count, minimum and memory
// a new request is taken while the previous result waits in the output register
// the execute state holds while the output register is occupied and not taken
// i_rst_n is synchronous, active low; it clears count, minimum and handshake
// state; the entry memory is not cleared, only entries below the count are read
module min_tracking_stack_unit
    import mts_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [OP_WIDTH-1:0]            i_op,
    input  logic signed [DATA_WIDTH-1:0]   i_push_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [DATA_WIDTH-1:0]   o_result_value,
    output logic                           o_stack_empty,
    output logic [STATUS_WIDTH-1:0]        o_status
);

    t_state                    r_state;
    logic [OP_WIDTH-1:0]       r_op;
    logic [DATA_WIDTH-1:0]     r_value;
    logic [COUNT_WIDTH-1:0]    r_count;
    logic [COUNT_WIDTH-1:0]    n_count;
    logic [DATA_WIDTH-1:0]     r_min;
    logic [DATA_WIDTH-1:0]     n_min;
    logic [ENTRY_WIDTH-1:0]    r_rd_data;
    logic                      r_out_valid;
    logic [DATA_WIDTH-1:0]     r_result;
    logic [DATA_WIDTH-1:0]     n_result;
    logic                      r_empty;
    logic [STATUS_WIDTH-1:0]   r_status;
    logic [STATUS_WIDTH-1:0]   n_status;

    logic [ENTRY_WIDTH-1:0]    mem [STACK_DEPTH];

    logic                      accept;
    logic                      fire;
    logic [COUNT_WIDTH-1:0]    count_m1;
    logic [ADDR_WIDTH-1:0]     rd_addr;
    logic                      wr_en;
    logic [ENTRY_WIDTH-1:0]    wr_data;
    logic                      is_empty;
    logic                      is_full;
    logic [ENTRY_WIDTH-1:0]    min_ext;
    logic [ENTRY_WIDTH-1:0]    val_ext;
    logic [ENTRY_WIDTH-1:0]    enc;
    logic                      top_below;
    logic                      push_below;
    logic [DATA_WIDTH-1:0]     dec_min;

    // handshake
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign fire       = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    // read address of the top entry
    assign count_m1 = r_count - COUNT_WIDTH'(1);
    assign rd_addr  = count_m1[ADDR_WIDTH-1:0];

    // entry arithmetic
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == COUNT_WIDTH'(STACK_DEPTH));
    assign min_ext    = {{2{r_min[DATA_WIDTH-1]}}, r_min};
    assign val_ext    = {{2{r_value[DATA_WIDTH-1]}}, r_value};
    assign enc        = {r_value[DATA_WIDTH-1], r_value, 1'b0} - min_ext;
    assign push_below = $signed(val_ext) < $signed(min_ext);
    assign top_below  = $signed(r_rd_data) < $signed(min_ext);
    assign dec_min    = {r_min[DATA_WIDTH-2:0], 1'b0} - r_rd_data[DATA_WIDTH-1:0];

    // execute step
    always_comb begin
        n_count  = r_count;
        n_min    = r_min;
        n_result = '0;
        n_status = STAT_OK;
        wr_en    = 1'b0;
        wr_data  = val_ext;
        case (r_op)
            OP_PUSH: begin
                if (is_full) begin
                    n_status = STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + COUNT_WIDTH'(1);
                    if (is_empty) begin
                        n_min = r_value;
                    end else if (push_below) begin
                        wr_data = enc;
                        n_min   = r_value;
                    end
                end
            end
            OP_POP, OP_PEEK: begin
                if (is_empty) begin
                    n_result = '1;
                    n_status = STAT_WAS_EMPTY;
                end else begin
                    if (top_below) begin
                        n_result = r_min;
                        if (r_op == OP_POP) begin
                            n_min = dec_min;
                        end
                    end else begin
                        n_result = r_rd_data[DATA_WIDTH-1:0];
                    end
                    if (r_op == OP_POP) begin
                        n_count = count_m1;
                    end
                end
            end
            OP_EMPTY: begin
                n_result = is_empty ? DATA_WIDTH'(1) : '0;
            end
            OP_MIN: begin
                if (is_empty) begin
                    n_result = '1;
                    n_status = STAT_WAS_EMPTY;
                end else begin
                    n_result = r_min;
                end
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (fire && wr_en) begin
            mem[r_count[ADDR_WIDTH-1:0]] <= wr_data;
        end
        if (accept) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_value <= i_push_value;
        end
    end

    // sequencer, count and minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (fire) begin
                r_count     <= n_count;
                r_min       <= n_min;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
            r_empty  <= (n_count == '0);
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_stack_empty  = r_empty;
    assign o_status       = r_status;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_WIDTH'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted transaction did not enter execute");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_empty == (r_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == STAT_FULL)) |-> is_full)
        else $error("full status without a full stack");

endmodule

@@ test/stack_result_checker.sv @@
module stack_result_checker
    import mts_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [OP_WIDTH-1:0]          i_op,
    input  logic signed [DATA_WIDTH-1:0] i_push_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic signed [DATA_WIDTH-1:0] i_result_value,
    input  logic                         i_stack_empty,
    input  logic [STATUS_WIDTH-1:0]      i_status,
    output int                           o_mismatches,
    output int                           o_awaited,
    output int                           o_checked,
    output int                           o_full_drops,
    output int                           o_min_restores
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         empty;
        logic [STATUS_WIDTH-1:0]      status;
    } t_response;

    // shadow copy of the stack, count and running minimum
    logic [ENTRY_WIDTH-1:0]       shadow_entries [STACK_DEPTH];
    int unsigned                  shadow_count;
    logic signed [DATA_WIDTH-1:0] shadow_min;

    t_response awaited_responses [$];
    t_response oldest;

    // apply one request to the shadow stack and return the response it should give
    function automatic t_response predict_stack_response(
        input logic [OP_WIDTH-1:0]          op,
        input logic signed [DATA_WIDTH-1:0] value
    );
        t_response resp;
        longint    val;
        longint    cur_min;
        longint    top;
        longint    enc;
        val          = value;
        cur_min      = shadow_min;
        resp.value   = '0;
        resp.status  = STAT_OK;
        case (op)
            OP_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    resp.status = STAT_FULL;
                    o_full_drops++;
                end else if (shadow_count != 0 && val < cur_min) begin
                    // new minimum: keep the old one folded into the entry
                    enc = 2 * val - cur_min;
                    shadow_entries[shadow_count] = enc[ENTRY_WIDTH-1:0];
                    shadow_min   = value;
                    shadow_count = shadow_count + 1;
                end else begin
                    if (shadow_count == 0)
                        shadow_min = value;
                    shadow_entries[shadow_count] = val[ENTRY_WIDTH-1:0];
                    shadow_count = shadow_count + 1;
                end
            end
            OP_POP, OP_PEEK: begin
                if (shadow_count == 0) begin
                    resp.value  = -1;
                    resp.status = STAT_WAS_EMPTY;
                end else begin
                    top = $signed(shadow_entries[shadow_count - 1]);
                    if (top < cur_min) begin
                        // encoded entry: the top value is the minimum itself
                        resp.value = shadow_min;
                        if (op == OP_POP) begin
                            enc        = 2 * cur_min - top;
                            shadow_min = enc[DATA_WIDTH-1:0];
                            o_min_restores++;
                        end
                    end else begin
                        resp.value = top[DATA_WIDTH-1:0];
                    end
                    if (op == OP_POP)
                        shadow_count = shadow_count - 1;
                end
            end
            OP_EMPTY: begin
                resp.value = (shadow_count == 0) ? 1 : 0;
            end
            OP_MIN: begin
                if (shadow_count == 0) begin
                    resp.value  = -1;
                    resp.status = STAT_WAS_EMPTY;
                end else begin
                    resp.value = shadow_min;
                end
            end
            default: begin
                // unused codes leave everything as it is
            end
        endcase
        resp.empty = (shadow_count == 0);
        return resp;
    endfunction

    // predict on every request transaction, compare on every result transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_min   = '0;
            awaited_responses.delete();
            o_mismatches   = 0;
            o_checked      = 0;
            o_full_drops   = 0;
            o_min_restores = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                awaited_responses.push_back(predict_stack_response(i_op, i_push_value));
            if (i_out_valid && i_out_ready) begin
                if (awaited_responses.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    o_mismatches++;
                end else begin
                    oldest = awaited_responses.pop_front();
                    o_checked++;
                    if (i_result_value !== oldest.value) begin
                        $error("result_value: expected %0d, got %0d",
                               oldest.value, i_result_value);
                        o_mismatches++;
                    end
                    if (i_stack_empty !== oldest.empty) begin
                        $error("stack_empty: expected %0b, got %0b",
                               oldest.empty, i_stack_empty);
                        o_mismatches++;
                    end
                    if (i_status !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, i_status);
                        o_mismatches++;
                    end
                end
            end
        end
        o_awaited = awaited_responses.size();
    end

endmodule

@@ test/tb_min_tracking_stack_unit.sv @@
module tb_min_tracking_stack_unit;
    import mts_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 10;
    localparam logic [OP_WIDTH-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_WIDTH-1:0] OP_UNUSED_LAST  = 3'd7;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         req_valid;
    logic                         req_ready;
    logic [OP_WIDTH-1:0]          req_op;
    logic signed [DATA_WIDTH-1:0] req_push_value;
    logic                         rsp_valid;
    logic                         rsp_ready;
    logic signed [DATA_WIDTH-1:0] rsp_result_value;
    logic                         rsp_stack_empty;
    logic [STATUS_WIDTH-1:0]      rsp_status;

    int mismatches;
    int awaited;
    int checked;
    int full_drops;
    int min_restores;
    int requests_sent;
    int directed_sent;
    int stall_cycles;
    bit steady;
    logic signed [DATA_WIDTH-1:0] descent;

    min_tracking_stack_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (req_valid),
        .o_in_ready     (req_ready),
        .i_op           (req_op),
        .i_push_value   (req_push_value),
        .o_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .o_result_value (rsp_result_value),
        .o_stack_empty  (rsp_stack_empty),
        .o_status       (rsp_status)
    );

    stack_result_checker u_result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (req_valid),
        .i_in_ready     (req_ready),
        .i_op           (req_op),
        .i_push_value   (req_push_value),
        .i_out_valid    (rsp_valid),
        .i_out_ready    (rsp_ready),
        .i_result_value (rsp_result_value),
        .i_stack_empty  (rsp_stack_empty),
        .i_status       (rsp_status),
        .o_mismatches   (mismatches),
        .o_awaited      (awaited),
        .o_checked      (checked),
        .o_full_drops   (full_drops),
        .o_min_restores (min_restores)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 38);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("min_tracking_stack_unit regression: fail");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(
        input logic [OP_WIDTH-1:0]          op,
        input logic signed [DATA_WIDTH-1:0] value
    );
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(0, 99) < 38)
                gap++;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_valid      <= 1'b1;
        req_op         <= op;
        req_push_value <= value;
        do
            @(posedge i_clk);
        while (!req_ready);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // hold off the request side until every result is back
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (awaited != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // mix of wide random, small, extreme and steadily falling values
    function automatic logic signed [DATA_WIDTH-1:0] pick_push_value();
        logic signed [DATA_WIDTH-1:0] val;
        case ($urandom_range(0, 9))
            0, 1, 2: val = $urandom();
            3, 4, 5: val = int'($urandom_range(0, 100)) - 50;
            6: begin
                case ($urandom_range(0, 3))
                    0:       val = 32'sh7fff_ffff;
                    1:       val = 32'sh8000_0000;
                    2:       val = -32'sd1;
                    default: val = 32'sd0;
                endcase
            end
            default: begin
                descent = descent - $urandom_range(1, 1000);
                val     = descent;
            end
        endcase
        return val;
    endfunction

    // one random request, leaning towards growing or shrinking the stack
    task automatic send_random_request(input bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (growing ? 55 : 25))
            send_request(OP_PUSH, pick_push_value());
        else if (roll < (growing ? 70 : 60))
            send_request(OP_POP, $urandom());
        else if (roll < (growing ? 78 : 70))
            send_request(OP_PEEK, $urandom());
        else if (roll < (growing ? 84 : 77))
            send_request(OP_EMPTY, $urandom());
        else if (roll < 93)
            send_request(OP_MIN, $urandom());
        else
            send_request(OP_WIDTH'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                         $urandom());
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_valid      = 1'b0;
        req_op         = OP_PUSH;
        req_push_value = '0;
        rsp_ready      = 1'b0;
        steady         = 1'b0;
        descent        = '0;
        requests_sent  = 0;
        stall_cycles   = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty stack, encoding at both extremes, unused codes
        send_request(OP_POP, 32'sd0);
        send_request(OP_PEEK, 32'sd0);
        send_request(OP_MIN, 32'sd0);
        send_request(OP_EMPTY, 32'sd0);
        send_request(OP_UNUSED_FIRST, 32'sh7fff_ffff);
        send_request(OP_PUSH, 32'sd7);
        send_request(OP_PUSH, 32'sh7fff_ffff);
        send_request(OP_PUSH, -32'sd1);
        send_request(OP_PUSH, 32'sh8000_0000);
        send_request(OP_PUSH, 32'sh8000_0000);
        send_request(OP_MIN, 32'sd0);
        send_request(OP_PEEK, 32'sd0);
        send_request(OP_POP, 32'sd0);
        send_request(OP_PEEK, 32'sd0);
        send_request(OP_POP, 32'sd0);
        send_request(OP_MIN, 32'sd0);
        send_request(OP_UNUSED_FIRST + 3'd1, -32'sd1);
        send_request(OP_UNUSED_LAST, 32'sh8000_0000);
        send_request(OP_EMPTY, 32'sd0);
        send_request(OP_POP, 32'sd0);
        send_request(OP_POP, 32'sd0);
        send_request(OP_POP, 32'sd0);
        send_request(OP_MIN, 32'sd0);
        send_request(OP_PUSH, 32'sh7fff_ffff);
        send_request(OP_PUSH, 32'sh8000_0000);
        directed_sent = requests_sent;

        // random, alternating growth and drain segments
        for (int seg = 0; seg < 8; seg++)
            for (int n = 0; n < 25; n++)
                send_random_request(seg % 2 == 0);

        // long stretch with both sides always willing
        steady = 1'b1;
        for (int n = 0; n < 100; n++)
            send_random_request(n < 70);
        steady = 1'b0;

        hold_until_drained();

        // build a deep stack, then pop it down with occasional minimum queries
        for (int n = 0; n < 100; n++)
            send_request(OP_PUSH, pick_push_value());
        send_request(OP_PEEK, $urandom());
        send_request(OP_MIN, $urandom());
        send_request(OP_EMPTY, $urandom());
        for (int n = 0; n < 104; n++)
            send_request(($urandom_range(0, 9) == 0) ? OP_MIN : OP_POP, $urandom());

        // tail of random traffic
        for (int n = 0; n < 20; n++)
            send_random_request($urandom_range(0, 1));

        req_valid <= 1'b0;
        while (awaited != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("sent %0d requests (%0d directed), checked %0d results",
                 requests_sent, directed_sent, checked);
        $display("%0d pushes refused on a full stack, %0d minimum restores on pop",
                 full_drops, min_restores);
        if (mismatches == 0)
            $display("min_tracking_stack_unit regression: pass");
        else
            $display("min_tracking_stack_unit regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mts_pkg.sv
hw/rtl/min_tracking_stack_unit.sv
test/stack_result_checker.sv
test/tb_min_tracking_stack_unit.sv
